### rtl/cgs_pkg.sv
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared types and constants of the color gradient sampler: stop layout,
// register indexes, queue entry and queue status.
// ----------------------------------------------------------------------------
`default_nettype none

package cgs_pkg;

  // fixed point and stop layout
  localparam int MAX_STOPS = 6;
  localparam int POS_W     = 17;               // unsigned Q1.16 position
  localparam int IN_W      = 18;               // signed Q1.16 sample position
  localparam int RGB_W     = 24;
  localparam int CH_W      = 8;
  localparam int CNT_W     = 3;                // stop count register width
  localparam int SEL_W     = 3;                // index over MAX_STOPS stops
  localparam int STOP_W    = POS_W + RGB_W;    // 41
  localparam int IDX_W     = 3;                // configuration index width
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = FRAC_W + 1;       // factor 0..65536
  localparam int REM_W     = POS_W + 1;
  localparam int DCNT_W    = 5;                // divider step counter
  localparam int PROD_W    = CH_W + QUO_W;     // 25

  localparam logic [POS_W-1:0] ONE_Q16 = POS_W'(1) << FRAC_W;

  // small queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_STOP_COUNT = 3'd0,
    REG_STOP_0     = 3'd1,
    REG_STOP_1     = 3'd2,
    REG_STOP_2     = 3'd3,
    REG_STOP_3     = 3'd4,
    REG_STOP_4     = 3'd5,
    REG_STOP_5     = 3'd6
  } cgs_reg_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } cgs_state_t;

  // one classified item: either a flat color (c0) or a span to interpolate
  typedef struct packed {
    logic             lerp;
    logic [POS_W-1:0] num;    // t - p0
    logic [POS_W-1:0] span;   // p1 - p0
    logic [RGB_W-1:0] c0;
    logic [RGB_W-1:0] c1;
  } cgs_item_t;

  // queue status toward front and back
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } cgs_qstat_t;

endpackage : cgs_pkg

`default_nettype wire

### rtl/color_gradient_sampler_unit.sv
// ----------------------------------------------------------------------------
// color_gradient_sampler_unit
// Piecewise linear color gradient: each sample position gives one RGB item.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_* writes register cfg_index: 0 is the stop count, 1..6 are the stops
//   (bits 40..24 position Q1.16, bits 23..0 red green blue). Write only while
//   no item is in flight; cfg_ready is always high.
//   in_* takes one signed Q1.16 sample position per item; out_* returns the
//   color of that position, one item for each input item, in order.
//   The front stage clamps and classifies each item as it is accepted and
//   places it in a two-entry queue; the back stage works one item at a time.
//   For a position inside a span the back end takes the item from the queue,
//   runs 17 steps of the bit-serial divider for the blend factor, blends
//   and passes the color to the output register; a position on or beyond
//   the end stops, or with no stops, skips the divide and blend steps.
//   While out_tready is low the output register holds its item and the back
//   stage waits with the next color; the queue still fills, then in_tready
//   drops. Reset clears the stop count and stops (black output) and empties
//   the queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module color_gradient_sampler_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [40:0] cfg_data,
  // sample input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [17:0] position, [23:18] zero
  // color output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [7:0] red, [15:8] green, [23:16] blue
);
  import cgs_pkg::*;

  cgs_item_t  wr_item;
  cgs_item_t  rd_item;
  cgs_qstat_t qstat;
  logic       push;
  logic       pop;

  cgs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_pos    (in_tdata[IN_W-1:0]),
    .qstat     (qstat),
    .push      (push),
    .item      (wr_item)
  );

  cgs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .qstat   (qstat)
  );

  cgs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .rd_item    (rd_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  // back end only takes an item that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // a push without a pop grows the queue by one item
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (qstat.count == $past(qstat.count) + QCNT_W'(1)))
    else $error("queue count did not follow push");

  // a pop without a push shrinks the queue by one item
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (qstat.count == $past(qstat.count) - QCNT_W'(1)))
    else $error("queue count did not follow pop");

endmodule : color_gradient_sampler_unit

`default_nettype wire

### rtl/cgs_front.sv
// ----------------------------------------------------------------------------
// cgs_front
// Holds the stop registers, clamps each sample position and classifies it
// into a flat color or an interpolation span for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cgs_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration writes
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [cgs_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [cgs_pkg::STOP_W-1:0]   cfg_data,
  // sample input
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [cgs_pkg::IN_W-1:0]     in_pos,
  // queue side
  input  wire cgs_pkg::cgs_qstat_t          qstat,
  output logic                              push,
  output cgs_pkg::cgs_item_t                item
);
  import cgs_pkg::*;

  logic [CNT_W-1:0]  stop_count_r, stop_count_nxt;
  logic [STOP_W-1:0] stop_r   [MAX_STOPS];
  logic [STOP_W-1:0] stop_nxt [MAX_STOPS];

  logic [POS_W-1:0] pos [MAX_STOPS];
  logic [RGB_W-1:0] rgb [MAX_STOPS];

  logic [CNT_W-1:0] n;
  logic [SEL_W-1:0] last;
  logic [POS_W-1:0] t;
  logic             found;
  logic [SEL_W-1:0] sel;
  logic [SEL_W-1:0] prev;

  assign cfg_ready = 1'b1;

  // register write decode
  always_comb begin
    stop_count_nxt = stop_count_r;
    for (int i = 0; i < MAX_STOPS; i++) begin
      stop_nxt[i] = stop_r[i];
    end
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STOP_COUNT: stop_count_nxt = cfg_data[CNT_W-1:0];
        default: begin
          if (cfg_index inside {[REG_STOP_0:REG_STOP_5]}) begin
            stop_nxt[SEL_W'(cfg_index - REG_STOP_0)] = cfg_data;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
        stop_r[i] <= '0;
      end
    end else begin
      stop_count_r <= stop_count_nxt;
      for (int i = 0; i < MAX_STOPS; i++) begin
        stop_r[i] <= stop_nxt[i];
      end
    end
  end

  // unpack stops
  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      pos[i] = stop_r[i][STOP_W-1:RGB_W];
      rgb[i] = stop_r[i][RGB_W-1:0];
    end
  end

  // clamp position and count
  always_comb begin
    if (in_pos[IN_W-1]) begin
      t = '0;
    end else if (in_pos[POS_W-1:0] > ONE_Q16) begin
      t = ONE_Q16;
    end else begin
      t = in_pos[POS_W-1:0];
    end
    n    = (stop_count_r > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : stop_count_r;
    last = SEL_W'(n - CNT_W'(1));
  end

  // first stop at or above t, searched from the second stop up
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = MAX_STOPS - 1; i >= 1; i--) begin
      if ((CNT_W'(i) < n) && (t <= pos[i])) begin
        found = 1'b1;
        sel   = SEL_W'(i);
      end
    end
    prev = sel - SEL_W'(1);
  end

  // classify
  always_comb begin
    item.lerp = 1'b0;
    item.num  = t - pos[prev];
    item.span = pos[sel] - pos[prev];
    item.c0   = rgb[prev];
    item.c1   = rgb[sel];
    if (n == '0) begin
      item.c0 = '0;
    end else if (t <= pos[0]) begin
      item.c0 = rgb[0];
    end else if (t >= pos[last]) begin
      item.c0 = rgb[last];
    end else if (found) begin
      item.lerp = 1'b1;
    end else begin
      item.c0 = rgb[last];
    end
  end

  // handshake
  assign in_tready = !qstat.full;
  assign push      = in_tvalid && in_tready;

endmodule : cgs_front

`default_nettype wire

### rtl/cgs_queue.sv
// ----------------------------------------------------------------------------
// cgs_queue
// Short register queue of classified items between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cgs_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire cgs_pkg::cgs_item_t   wr_item,
  input  wire logic                 pop,
  output cgs_pkg::cgs_item_t        rd_item,
  output cgs_pkg::cgs_qstat_t       qstat
);
  import cgs_pkg::*;

  cgs_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item     = mem_r[rd_ptr_r];
  assign qstat.full  = (count_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign qstat.count = count_r;

endmodule : cgs_queue

`default_nettype wire

### rtl/cgs_back.sv
// ----------------------------------------------------------------------------
// cgs_back
// Takes classified items from the queue; for a span it divides for the blend
// factor one bit per cycle and blends the three channels; holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module cgs_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cgs_pkg::cgs_qstat_t        qstat,
  input  wire cgs_pkg::cgs_item_t         rd_item,
  output logic                            pop,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [cgs_pkg::RGB_W-1:0]       out_tdata
);
  import cgs_pkg::*;

  cgs_state_t state_r, state_nxt;

  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [POS_W-1:0]  span_r, span_nxt;
  logic [RGB_W-1:0]  c0_r, c0_nxt;
  logic [RGB_W-1:0]  c1_r, c1_nxt;
  logic [RGB_W-1:0]  res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RGB_W-1:0]  out_data_r, out_data_nxt;

  logic              load_out;
  logic [REM_W-1:0]  trial;
  logic              qbit;
  logic [QUO_W-1:0]  inv_f;
  logic [PROD_W-1:0] blend [3];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          state_nxt = rd_item.lerp ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: pop      = !qstat.empty;
      ST_DONE: load_out = !out_valid_r || out_tready;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // restoring divide step: first step compares num itself, later ones shift
  always_comb begin
    trial = (cnt_r == DCNT_W'(QUO_W - 1)) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
    qbit  = (trial >= REM_W'(span_r));
  end

  // channel blend, c0 * (1 - f) + c1 * f
  always_comb begin
    inv_f = QUO_W'(ONE_Q16) - quo_r;
    for (int ch = 0; ch < 3; ch++) begin
      blend[ch] = PROD_W'(c0_r[ch*CH_W +: CH_W]) * PROD_W'(inv_f)
                + PROD_W'(c1_r[ch*CH_W +: CH_W]) * PROD_W'(quo_r);
    end
  end

  // datapath
  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    span_nxt = span_r;
    c0_nxt   = c0_r;
    c1_nxt   = c1_r;
    res_nxt  = res_r;
    if (pop) begin
      cnt_nxt  = DCNT_W'(QUO_W - 1);
      rem_nxt  = REM_W'(rd_item.num);
      quo_nxt  = '0;
      span_nxt = rd_item.span;
      c0_nxt   = rd_item.c0;
      c1_nxt   = rd_item.c1;
      res_nxt  = rd_item.c0;
    end else if (state_r == ST_DIV) begin
      rem_nxt = qbit ? (trial - REM_W'(span_r)) : trial;
      quo_nxt = {quo_r[QUO_W-2:0], qbit};
      cnt_nxt = cnt_r - DCNT_W'(1);
    end else if (state_r == ST_MUL) begin
      for (int ch = 0; ch < 3; ch++) begin
        res_nxt[ch*CH_W +: CH_W] = blend[ch][FRAC_W +: CH_W];
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = load_out || (out_valid_r && !out_tready);
    out_data_nxt  = load_out ? res_r : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    span_r     <= span_nxt;
    c0_r       <= c0_nxt;
    c1_r       <= c1_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // red lowest, then green, then blue
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r[CH_W-1:0], out_data_r[2*CH_W-1:CH_W],
                       out_data_r[RGB_W-1:2*CH_W]};

endmodule : cgs_back

`default_nettype wire
